[design/pct_pkg.sv]
// shared types, codes and defaults for the pareto constraint set table
package pct_pkg;

  localparam int OBJECT_COUNT_DEF = 32;
  localparam int TABLE_DEPTH_DEF  = 16;
  localparam int COST_WIDTH_DEF   = 32;

  localparam int MASK_FIELD_W  = 32;
  localparam int COST_FIELD_W  = 32;
  localparam int TOL_W         = 16;
  localparam int COUNT_FIELD_W = 5;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] ST_REJECTED = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [MASK_FIELD_W-1:0] object_mask;
    logic [COST_FIELD_W-1:0] path_cost;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PRUNE,
    S_APPEND,
    S_RESP
  } state_t;

endpackage

[design/pareto_constraint_set_table_top.sv]
// top level of the pareto constraint set table with dominance pruning
//
// requests arrive on in_valid/in_ready carrying an operation, an object
// set and a cost; each request gives exactly one result on out_valid/
// out_ready with a status and the entry count after the operation.
// the tolerance register is written through cfg_valid/cfg_ready, which is
// always ready; write it only while no request is in flight.
// insert makes a dominance pass over the table in the entry memory, one
// entry read per cycle through the single read port, that stops early at
// a rejection or at the first equal set; unless rejected it then makes a
// prune/compact pass over all entries held, then an append step and a
// result step. append takes the append and result steps, clear the result step.
// one request is worked on at a time; a new request is taken while the
// previous result still waits in the output register.
// reset empties the table (count to zero), sets the tolerance to one and
// drops any pending result; the memory itself is not cleared.
// when the receiver stalls the finished result holds in the output
// register and the next result waits in its response state.
module pareto_constraint_set_table_top
  import pct_pkg::*;
#(
  parameter int OBJECT_COUNT = OBJECT_COUNT_DEF,
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int COST_WIDTH   = COST_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data
);

  // stored widths: field bits above the object count or cost width are ignored
  localparam int MASK_W = (OBJECT_COUNT < MASK_FIELD_W) ? OBJECT_COUNT : MASK_FIELD_W;
  localparam int COST_W = (COST_WIDTH < COST_FIELD_W) ? COST_WIDTH : COST_FIELD_W;
  localparam int ENT_W  = MASK_W + COST_W;
  localparam int SUM_W  = ((COST_W > TOL_W) ? COST_W : TOL_W) + 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;     // valid entries
  logic [CNT_W-1:0]  rd_idx, rd_idx_next;   // next entry to read
  logic [CNT_W-1:0]  wr_idx, wr_idx_next;   // compaction write pointer
  logic              pend, pend_next;       // read data valid this cycle
  logic [1:0]        status, status_next;
  logic [TOL_W-1:0]  tol;

  // captured request
  logic [MASK_W-1:0] mask_q;
  logic [COST_W-1:0] cost_q;

  // memory ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  // entry under test
  logic [MASK_W-1:0] em;
  logic [COST_W-1:0] ec;
  logic              ent_in_new;   // entry set is a subset of the new set
  logic              new_in_ent;   // new set is a subset of the entry set
  logic              same_set;
  logic              lower;        // entry cost lower by more than tolerance

  pct_entry_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AW),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign em         = ram_rdata[ENT_W-1:COST_W];
  assign ec         = ram_rdata[COST_W-1:0];
  assign ent_in_new = (em & ~mask_q) == '0;
  assign new_in_ent = (mask_q & ~em) == '0;
  assign same_set   = em == mask_q;
  assign lower      = (SUM_W'(ec) + SUM_W'(tol)) < SUM_W'(cost_q);

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid) begin
      tol <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mask_q <= in_item.object_mask[MASK_W-1:0];
      cost_q <= in_item.path_cost[COST_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    wr_idx <= wr_idx_next;
    status <= status_next;
  end

  // sequencer: dominance walk, prune and compact, append, respond
  always_comb begin
    state_next  = state;
    count_next  = count;
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    pend_next   = 1'b0;
    status_next = status;
    ram_we      = 1'b0;
    ram_waddr   = wr_idx[AW-1:0];
    ram_wdata   = ram_rdata;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd_idx_next = '0;
          case (in_item.operation)
            OP_INSERT: state_next = S_CHECK;
            OP_APPEND: state_next = S_APPEND;
            OP_CLEAR: begin
              count_next  = '0;
              status_next = ST_DONE;
              state_next  = S_RESP;
            end
            default: begin
              status_next = ST_DONE;
              state_next  = S_RESP;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (pend && ent_in_new && lower) begin
          status_next = ST_REJECTED;
          state_next  = S_RESP;
        end else if ((pend && ent_in_new && same_set) || rd_idx == count) begin
          // first equal subset or end of table: no rejection
          rd_idx_next = '0;
          wr_idx_next = '0;
          state_next  = S_PRUNE;
        end else begin
          rd_idx_next = rd_idx + CNT_W'(1);
          pend_next   = 1'b1;
        end
      end
      S_PRUNE: begin
        // writes trail reads, so a kept entry never lands on one still unread
        if (pend && !(new_in_ent && !lower)) begin
          ram_we      = 1'b1;
          wr_idx_next = wr_idx + CNT_W'(1);
        end
        if (rd_idx == count) begin
          count_next = wr_idx_next;
          state_next = S_APPEND;
        end else begin
          rd_idx_next = rd_idx + CNT_W'(1);
          pend_next   = 1'b1;
        end
      end
      S_APPEND: begin
        if (count == CNT_W'(TABLE_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = count[AW-1:0];
          ram_wdata   = {mask_q, cost_q};
          count_next  = count + CNT_W'(1);
          status_next = ST_DONE;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && (!out_valid || out_ready)) begin
      out_item.status      <= status;
      out_item.entry_count <= COUNT_FIELD_W'(count);
    end
  end

endmodule

[design/pct_entry_ram.sv]
// entry memory: one write port, one read port with registered read data
module pct_entry_ram #(
  parameter int DEPTH   = 16,
  parameter int ADDR_W  = 4,
  parameter int DATA_W  = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
